// File: rtl/rgbeg_pkg.sv
// Shared types, constants and color functions of the RGB effect generator.
`default_nettype none

package rgbeg_pkg;

    // Configuration port geometry and register indexes.
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 8;

    localparam logic [CfgIdxWidth-1:0] CfgEnable      = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgEffectMode  = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgSpeedLevel  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgBrightness  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgTouchEnable = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CfgTouchHue    = 3'd5;

    // Effect modes.
    localparam logic [3:0] ModeRed       = 4'd0;
    localparam logic [3:0] ModeWhite     = 4'd6;
    localparam logic [3:0] ModeStep3     = 4'd7;
    localparam logic [3:0] ModeStep7     = 4'd8;
    localparam logic [3:0] ModeBreathe3  = 4'd9;
    localparam logic [3:0] ModeBreathe7  = 4'd10;
    localparam logic [3:0] ModeRainbow   = 4'd11;

    // Register values after reset.
    localparam logic [3:0] ModeReset   = 4'd3;
    localparam logic [2:0] SpeedReset  = 3'd4;
    localparam logic [3:0] BrightReset = 4'd5;
    localparam logic [2:0] SpeedMax    = 3'd6;

    localparam logic [7:0] Full = 8'd255;

    // Period tables in ticks, indexed by the clamped speed level.
    localparam logic [12:0] StepPeriod [7] = '{
        13'd4800, 13'd2400, 13'd1200, 13'd600, 13'd300, 13'd150, 13'd75
    };
    localparam logic [12:0] FadePeriod [7] = '{
        13'd12, 13'd10, 13'd8, 13'd6, 13'd4, 13'd2, 13'd1
    };

    // Channel mask of each palette color: bit 2 red, bit 1 green, bit 0 blue.
    localparam logic [2:0] PaletteMask [7] = '{
        3'd4, 3'd2, 3'd1, 3'd6, 3'd5, 3'd3, 3'd7
    };

    // (level + 1) * 3277; a product with it shifted right by 15 equals a divide by ten
    // for every color byte and brightness level.
    localparam logic [15:0] ScaleCoef [16] = '{
        16'd3277,  16'd6554,  16'd9831,  16'd13108, 16'd16385, 16'd19662,
        16'd22939, 16'd26216, 16'd29493, 16'd32770, 16'd36047, 16'd39324,
        16'd42601, 16'd45878, 16'd49155, 16'd52432
    };
    localparam int ScaleShift = 15;

    typedef struct packed {
        logic       enable;
        logic [3:0] effect_mode;
        logic [2:0] speed_level;
        logic [3:0] brightness;
        logic       touch_enable;
        logic [7:0] touch_hue;
    } t_cfg;

    typedef struct packed {
        logic effect;
        logic base;
    } t_clr;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic zero;
        logic raw;
    } t_mid_ctl;

    typedef struct packed {
        logic advance;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_duty;
        logic [7:0] green_duty;
        logic [7:0] blue_duty;
    } t_out_item;

    // Palette color k at the given level; indexes past the last color show white.
    function automatic t_rgb palette(logic [2:0] k, logic [7:0] level);
        logic [2:0] m;
        t_rgb       c;
        begin
            m = PaletteMask[(k > 3'd6) ? 3'd6 : k];
            c.red   = m[2] ? level : 8'd0;
            c.green = m[1] ? level : 8'd0;
            c.blue  = m[0] ? level : 8'd0;
            return c;
        end
    endfunction

    // Hue ramp with slope six, saturating at full scale.
    function automatic logic [7:0] ramp(logic [7:0] x);
        logic [10:0] v;
        begin
            v = {1'b0, x, 2'b00} + {2'b00, x, 1'b0};
            return (v > 11'd255) ? Full : v[7:0];
        end
    endfunction

    // Color wheel byte to RGB in six segments.
    function automatic t_rgb touch_color(logic [7:0] h);
        t_rgb c;
        begin
            if (h < 8'd44) begin
                c = '{8'd0, ramp(h), Full};
            end else if (h < 8'd87) begin
                c = '{8'd0, Full, Full - ramp(h - 8'd43)};
            end else if (h < 8'd130) begin
                c = '{ramp(h - 8'd86), Full, 8'd0};
            end else if (h < 8'd173) begin
                c = '{Full, Full - ramp(h - 8'd129), 8'd0};
            end else if (h < 8'd216) begin
                c = '{Full, 8'd0, ramp(h - 8'd172)};
            end else begin
                c = '{Full - ramp(h - 8'd212), 8'd0, Full};
            end
            return c;
        end
    endfunction

    // Rainbow sweep color; phases past five hold the last phase.
    function automatic t_rgb rainbow_color(logic [2:0] ph, logic [7:0] f);
        t_rgb c;
        begin
            case (ph)
                3'd0: c = '{Full, f, 8'd0};
                3'd1: c = '{Full - f, Full, 8'd0};
                3'd2: c = '{8'd0, Full, f};
                3'd3: c = '{8'd0, Full - f, Full};
                3'd4: c = '{f, 8'd0, Full};
                default: c = '{Full, 8'd0, Full - f};
            endcase
            return c;
        end
    endfunction

    // Duty = c * (level + 1) / 10, saturated to a byte.
    function automatic logic [7:0] scale_duty(logic [7:0] c, logic [3:0] level);
        logic [23:0] p;
        begin
            p = {16'd0, c} * {8'd0, ScaleCoef[level]};
            return p[23] ? Full : p[ScaleShift+7:ScaleShift];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/rgbeg_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
`default_nettype none

interface rgbeg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/rgbeg_effect.sv
// Effect state machine: tick pacing, phase and fade tracking, base color update.
`default_nettype none

module rgbeg_effect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbeg_pkg::t_cfg     i_cfg,
    input  rgbeg_pkg::t_clr     i_clr,
    input  logic                i_fire,
    input  logic                i_advance,
    output rgbeg_pkg::t_rgb     o_base,
    output rgbeg_pkg::t_mid_ctl o_ctl
);

    logic [12:0]         r_tick, n_tick;
    logic [2:0]          r_phase, n_phase;
    logic [7:0]          r_fade, n_fade;
    logic                r_down, n_down;
    rgbeg_pkg::t_rgb     r_base, n_base;
    rgbeg_pkg::t_mid_ctl r_ctl, n_ctl;

    logic [3:0]  mode_c;
    logic [2:0]  speed_c;
    logic        is_step;
    logic [12:0] period;
    logic [12:0] tick_inc;
    logic        due;
    logic [2:0]  last_color;
    logic [2:0]  phase_inc;
    logic [2:0]  phase_wrap;
    logic [2:0]  rainbow_wrap;

    // Clamp mode and speed, then pick the period of the active table.
    assign mode_c  = (i_cfg.effect_mode > rgbeg_pkg::ModeRainbow) ?
                     rgbeg_pkg::ModeRainbow : i_cfg.effect_mode;
    assign speed_c = (i_cfg.speed_level > rgbeg_pkg::SpeedMax) ?
                     rgbeg_pkg::SpeedMax : i_cfg.speed_level;
    assign is_step = (mode_c == rgbeg_pkg::ModeStep3) || (mode_c == rgbeg_pkg::ModeStep7);
    assign period  = is_step ? rgbeg_pkg::StepPeriod[speed_c] :
                     rgbeg_pkg::FadePeriod[speed_c];

    // Tick pacing: the counter rolls over when it reaches the period.
    assign tick_inc = r_tick + 13'd1;
    assign due      = (tick_inc >= period);

    // Phase stepping for the three and seven color lists and for the rainbow.
    assign last_color   = ((mode_c == rgbeg_pkg::ModeStep3) ||
                           (mode_c == rgbeg_pkg::ModeBreathe3)) ? 3'd2 : 3'd6;
    assign phase_inc    = r_phase + 3'd1;
    assign phase_wrap   = (phase_inc > last_color) ? 3'd0 : phase_inc;
    assign rainbow_wrap = (phase_inc >= 3'd6) ? 3'd0 : phase_inc;

    // Next effect state and base color for one item.
    always_comb begin
        n_tick  = r_tick;
        n_phase = r_phase;
        n_fade  = r_fade;
        n_down  = r_down;
        n_base  = r_base;
        n_ctl   = r_ctl;

        if (i_fire) begin
            n_ctl.zero = !i_cfg.enable;
            n_ctl.raw  = !i_cfg.touch_enable && (mode_c >= rgbeg_pkg::ModeBreathe3);

            if (!i_cfg.enable) begin
                n_tick  = '0;
                n_phase = '0;
                n_fade  = '0;
                n_down  = 1'b0;
            end else if (i_cfg.touch_enable) begin
                n_base = rgbeg_pkg::touch_color(i_cfg.touch_hue);
            end else if (i_advance) begin
                case (mode_c) inside
                    [rgbeg_pkg::ModeRed:rgbeg_pkg::ModeWhite]: begin
                        n_base = rgbeg_pkg::palette(mode_c[2:0], rgbeg_pkg::Full);
                    end
                    rgbeg_pkg::ModeStep3, rgbeg_pkg::ModeStep7: begin
                        n_tick = due ? 13'd0 : tick_inc;
                        if (due) begin
                            n_phase = phase_wrap;
                        end
                        n_base = rgbeg_pkg::palette(
                            (n_phase > last_color) ? last_color : n_phase, rgbeg_pkg::Full);
                    end
                    rgbeg_pkg::ModeBreathe3, rgbeg_pkg::ModeBreathe7: begin
                        n_tick = due ? 13'd0 : tick_inc;
                        if (due) begin
                            if (!r_down) begin
                                if (r_fade != rgbeg_pkg::Full) begin
                                    n_fade = r_fade + 8'd1;
                                    if (n_fade == rgbeg_pkg::Full) begin
                                        n_down = 1'b1;
                                    end
                                end
                            end else begin
                                if (r_fade != 8'd0) begin
                                    n_fade = r_fade - 8'd1;
                                end
                                if (n_fade == 8'd0) begin
                                    n_down  = 1'b0;
                                    n_phase = phase_wrap;
                                end
                            end
                        end
                        n_base = rgbeg_pkg::palette(
                            (n_phase > last_color) ? last_color : n_phase, n_fade);
                    end
                    default: begin
                        n_tick = due ? 13'd0 : tick_inc;
                        if (due) begin
                            if (r_fade != rgbeg_pkg::Full) begin
                                n_fade = r_fade + 8'd1;
                            end else begin
                                n_fade  = 8'd0;
                                n_phase = rainbow_wrap;
                            end
                        end
                        n_base = rgbeg_pkg::rainbow_color(n_phase, n_fade);
                    end
                endcase
            end
        end

        // Register writes that reset the effect take priority.
        if (i_clr.effect) begin
            n_tick  = '0;
            n_phase = '0;
            n_fade  = '0;
            n_down  = 1'b0;
        end
        if (i_clr.base) begin
            n_base = '0;
        end
    end

    // Effect state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_phase <= '0;
            r_fade  <= '0;
            r_down  <= 1'b0;
            r_base  <= '0;
            r_ctl   <= '0;
        end else begin
            r_tick  <= n_tick;
            r_phase <= n_phase;
            r_fade  <= n_fade;
            r_down  <= n_down;
            r_base  <= n_base;
            r_ctl   <= n_ctl;
        end
    end

    assign o_base = r_base;
    assign o_ctl  = r_ctl;

    // A disabled item clears the effect state.
    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_cfg.enable) |=>
        (r_tick == 13'd0 && r_phase == 3'd0 && r_fade == 8'd0 && !r_down))
        else $error("effect state not cleared by a disabled item");

    // Fading down always starts from a nonzero level and stops at zero.
    a_down_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_down |-> (r_fade != 8'd0))
        else $error("fading down with a zero fade level");

    // The phase never reaches the unused code and the counter stays below the longest period.
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != 3'd7) && (r_tick < 13'd4800))
        else $error("effect phase or tick counter out of range");

endmodule

`default_nettype wire

// File: rtl/rgbeg_scale.sv
// Output stage: brightness scaling, bypass and blanking into the result register.
`default_nettype none

module rgbeg_scale (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  rgbeg_pkg::t_rgb       i_base,
    input  rgbeg_pkg::t_mid_ctl   i_ctl,
    input  logic [3:0]            i_brightness,
    output rgbeg_pkg::t_out_item  o_item
);

    rgbeg_pkg::t_out_item r_out, n_out;

    // Blank when disabled, pass the base color in breathe and rainbow modes without touch, else scale.
    always_comb begin
        if (i_ctl.zero) begin
            n_out = '0;
        end else if (i_ctl.raw) begin
            n_out.red_duty   = i_base.red;
            n_out.green_duty = i_base.green;
            n_out.blue_duty  = i_base.blue;
        end else begin
            n_out.red_duty   = rgbeg_pkg::scale_duty(i_base.red, i_brightness);
            n_out.green_duty = rgbeg_pkg::scale_duty(i_base.green, i_brightness);
            n_out.blue_duty  = rgbeg_pkg::scale_duty(i_base.blue, i_brightness);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

// File: rtl/rgb_effect_generator.sv
// RGB lamp effect generator top level: configuration registers and the item pipeline.
// Pipeline: an accepted item passes through the input register, the effect state register
// and the result register.
// Throughput: one item per cycle; the valid/ready pipeline stalls only on the result side.
// Reset (synchronous, active low) restores the register defaults and clears all effect state.
`default_nettype none

module rgb_effect_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgbeg_pkg::CfgIdxWidth-1:0]   i_cfg_idx,
    input  logic [rgbeg_pkg::CfgDataWidth-1:0]  i_cfg_data,
    rgbeg_stream_if.sink                        i_item,
    rgbeg_stream_if.source                      o_result
);

    rgbeg_pkg::t_cfg     r_cfg;
    rgbeg_pkg::t_clr     clr;
    rgbeg_pkg::t_rgb     base;
    rgbeg_pkg::t_mid_ctl mid_ctl;
    rgbeg_pkg::t_out_item out_item;

    logic r_in_valid;
    logic r_in_advance;
    logic r_mid_valid;
    logic r_out_valid;

    logic out_free;
    logic mid_to_out;
    logic mid_free;
    logic in_to_mid;
    logic in_free;
    logic accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable       <= 1'b0;
            r_cfg.effect_mode  <= rgbeg_pkg::ModeReset;
            r_cfg.speed_level  <= rgbeg_pkg::SpeedReset;
            r_cfg.brightness   <= rgbeg_pkg::BrightReset;
            r_cfg.touch_enable <= 1'b0;
            r_cfg.touch_hue    <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rgbeg_pkg::CfgEnable:      r_cfg.enable       <= i_cfg_data[0];
                rgbeg_pkg::CfgEffectMode:  r_cfg.effect_mode  <= i_cfg_data[3:0];
                rgbeg_pkg::CfgSpeedLevel:  r_cfg.speed_level  <= i_cfg_data[2:0];
                rgbeg_pkg::CfgBrightness:  r_cfg.brightness   <= i_cfg_data[3:0];
                rgbeg_pkg::CfgTouchEnable: r_cfg.touch_enable <= i_cfg_data[0];
                rgbeg_pkg::CfgTouchHue:    r_cfg.touch_hue    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Disabling the lamp clears the effect; a mode write also clears the base color.
    assign clr.effect = i_cfg_we &&
                        (((i_cfg_idx == rgbeg_pkg::CfgEnable) && !i_cfg_data[0]) ||
                         (i_cfg_idx == rgbeg_pkg::CfgEffectMode));
    assign clr.base   = i_cfg_we && (i_cfg_idx == rgbeg_pkg::CfgEffectMode);

    // Pipeline flow: each stage moves when the next one is empty or emptying.
    assign out_free   = !r_out_valid || o_result.ready;
    assign mid_to_out = r_mid_valid && out_free;
    assign mid_free   = !r_mid_valid || mid_to_out;
    assign in_to_mid  = r_in_valid && mid_free;
    assign in_free    = !r_in_valid || in_to_mid;
    assign accept     = i_item.valid && in_free;

    assign i_item.ready = in_free;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= accept || (r_in_valid && !in_to_mid);
            r_mid_valid <= in_to_mid || (r_mid_valid && !mid_to_out);
            r_out_valid <= mid_to_out || (r_out_valid && !o_result.ready);
        end
    end

    // Input item register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_advance <= i_item.payload.advance;
        end
    end

    rgbeg_effect u_effect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_clr     (clr),
        .i_fire    (in_to_mid),
        .i_advance (r_in_advance),
        .o_base    (base),
        .o_ctl     (mid_ctl)
    );

    rgbeg_scale u_scale (
        .i_clk        (i_clk),
        .i_load       (mid_to_out),
        .i_base       (base),
        .i_ctl        (mid_ctl),
        .i_brightness (r_cfg.brightness),
        .o_item       (out_item)
    );

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = out_item;

    // An item taken while the lamp is disabled yields an all-zero result.
    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mid_to_out && mid_ctl.zero) |=>
        (out_item.red_duty == 8'd0 && out_item.green_duty == 8'd0 &&
         out_item.blue_duty == 8'd0 && r_out_valid))
        else $error("disabled item produced a nonzero result");

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the RGB effect generator: directed table, then random effect runs.
`timescale 1ns / 100ps

module tb;

    localparam int RandItems = 2000;
    localparam int HangLimit = 5000;
    localparam int StallCycles = 64;
    localparam int DrainCycles = 8;

    // Codes this bench needs beyond the package: the top mode value and the spare index.
    localparam logic [3:0] ModeLast = 4'd15;
    localparam logic [rgbeg_pkg::CfgIdxWidth-1:0] CfgSpare = 3'd7;

    // Channel mask of each palette color: red, green, blue, yellow, purple, cyan, white.
    localparam logic [2:0] ChanMask [7] = '{
        3'b100, 3'b010, 3'b001, 3'b110, 3'b101, 3'b011, 3'b111
    };

    // One row of the directed stimulus: a register write or an item with an optional
    // hand-computed result.
    typedef struct packed {
        logic                               is_cfg;
        logic [rgbeg_pkg::CfgIdxWidth-1:0]  idx;
        logic [rgbeg_pkg::CfgDataWidth-1:0] data;
        logic                               adv;
        logic                               typed;
        rgbeg_pkg::t_out_item               want;
    } t_stim_row;

    function automatic t_stim_row wr(logic [rgbeg_pkg::CfgIdxWidth-1:0] idx,
                                     logic [rgbeg_pkg::CfgDataWidth-1:0] data);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_stim_row tick(logic adv);
        t_stim_row r;
        r = '0;
        r.adv = adv;
        return r;
    endfunction

    function automatic t_stim_row tick_is(logic adv, logic [7:0] red, logic [7:0] green,
                                          logic [7:0] blue);
        t_stim_row r;
        r = tick(adv);
        r.typed = 1'b1;
        r.want.red_duty = red;
        r.want.green_duty = green;
        r.want.blue_duty = blue;
        return r;
    endfunction

    localparam int NumDir = 49;
    localparam t_stim_row DirRows [NumDir] = '{
        // Disabled after reset, then static colors at the brightness extremes.
        tick_is(1'b1, 8'd0, 8'd0, 8'd0),
        wr(rgbeg_pkg::CfgBrightness, 8'd9),
        wr(rgbeg_pkg::CfgEnable, 8'd1),
        wr(rgbeg_pkg::CfgEffectMode, 8'(rgbeg_pkg::ModeRed)),
        tick_is(1'b1, 8'd255, 8'd0, 8'd0),
        wr(rgbeg_pkg::CfgBrightness, 8'd15),
        tick_is(1'b0, 8'd255, 8'd0, 8'd0),
        wr(rgbeg_pkg::CfgBrightness, 8'd0),
        tick_is(1'b1, 8'd25, 8'd0, 8'd0),
        wr(rgbeg_pkg::CfgBrightness, 8'd9),
        wr(rgbeg_pkg::CfgEffectMode, 8'(rgbeg_pkg::ModeWhite)),
        tick_is(1'b0, 8'd0, 8'd0, 8'd0),
        tick_is(1'b1, 8'd255, 8'd255, 8'd255),
        // Step modes at the speed extremes, speed seven included.
        wr(rgbeg_pkg::CfgSpeedLevel, 8'd7),
        wr(rgbeg_pkg::CfgEffectMode, 8'(rgbeg_pkg::ModeStep3)),
        tick(1'b1),
        tick(1'b1),
        wr(rgbeg_pkg::CfgSpeedLevel, 8'd0),
        wr(rgbeg_pkg::CfgEffectMode, 8'(rgbeg_pkg::ModeStep7)),
        tick(1'b1),
        // Breathing and rainbow start from zero after the mode write.
        wr(rgbeg_pkg::CfgSpeedLevel, 8'(rgbeg_pkg::SpeedMax)),
        wr(rgbeg_pkg::CfgEffectMode, 8'(rgbeg_pkg::ModeBreathe3)),
        tick_is(1'b1, 8'd1, 8'd0, 8'd0),
        tick_is(1'b1, 8'd2, 8'd0, 8'd0),
        wr(rgbeg_pkg::CfgEffectMode, 8'(rgbeg_pkg::ModeBreathe7)),
        tick_is(1'b1, 8'd1, 8'd0, 8'd0),
        wr(rgbeg_pkg::CfgEffectMode, 8'(rgbeg_pkg::ModeRainbow)),
        tick_is(1'b1, 8'd255, 8'd1, 8'd0),
        wr(rgbeg_pkg::CfgEffectMode, 8'(ModeLast)),
        tick_is(1'b1, 8'd255, 8'd1, 8'd0),
        wr(CfgSpare, 8'hFF),
        // Touch hue at the segment edges, where the ramp saturates.
        wr(rgbeg_pkg::CfgTouchEnable, 8'd1),
        wr(rgbeg_pkg::CfgTouchHue, 8'd0),
        tick_is(1'b1, 8'd0, 8'd0, 8'd255),
        wr(rgbeg_pkg::CfgTouchHue, 8'd43),
        tick_is(1'b1, 8'd0, 8'd255, 8'd255),
        wr(rgbeg_pkg::CfgTouchHue, 8'd86),
        tick_is(1'b0, 8'd0, 8'd255, 8'd0),
        wr(rgbeg_pkg::CfgTouchHue, 8'd129),
        tick_is(1'b1, 8'd255, 8'd255, 8'd0),
        wr(rgbeg_pkg::CfgTouchHue, 8'd172),
        tick_is(1'b1, 8'd255, 8'd0, 8'd0),
        wr(rgbeg_pkg::CfgTouchHue, 8'd215),
        tick_is(1'b1, 8'd255, 8'd0, 8'd255),
        wr(rgbeg_pkg::CfgTouchHue, 8'd255),
        tick_is(1'b1, 8'd0, 8'd0, 8'd255),
        wr(rgbeg_pkg::CfgTouchEnable, 8'd0),
        wr(rgbeg_pkg::CfgEnable, 8'd0),
        tick_is(1'b1, 8'd0, 8'd0, 8'd0)
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [rgbeg_pkg::CfgIdxWidth-1:0]  i_cfg_idx = '0;
    logic [rgbeg_pkg::CfgDataWidth-1:0] i_cfg_data = '0;

    rgbeg_stream_if #(.t_payload(rgbeg_pkg::t_in_item))  in_ch ();
    rgbeg_stream_if #(.t_payload(rgbeg_pkg::t_out_item)) out_ch ();

    rgb_effect_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch),
        .o_result   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the lamp registers and the effect state.
    rgbeg_pkg::t_cfg lamp_cfg;
    logic [12:0]     fx_tick;
    logic [2:0]      fx_phase;
    logic [7:0]      fx_fade;
    logic            fx_down;
    rgbeg_pkg::t_rgb base;

    rgbeg_pkg::t_out_item pending_duties [$];
    int        duty_errors = 0;
    int        duties_checked = 0;
    int        dir_items = 0;
    int        rand_items = 0;
    int        setting_changes = 0;
    int        send_idle_pct = 32;
    int        recv_idle_pct = 81;
    int        stall_left = 0;
    bit        stall_request = 1'b0;
    int        quiet_cycles = 0;

    function automatic void clear_fx();
        fx_tick = '0;
        fx_phase = '0;
        fx_fade = '0;
        fx_down = 1'b0;
    endfunction

    function automatic void set_base(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        base.red = red;
        base.green = green;
        base.blue = blue;
    endfunction

    function automatic void load_cfg(logic [rgbeg_pkg::CfgIdxWidth-1:0] idx,
                                     logic [rgbeg_pkg::CfgDataWidth-1:0] d);
        case (idx)
            rgbeg_pkg::CfgEnable: begin
                lamp_cfg.enable = d[0];
                if (!d[0]) clear_fx();
            end
            rgbeg_pkg::CfgEffectMode: begin
                lamp_cfg.effect_mode = d[3:0];
                clear_fx();
                set_base(8'd0, 8'd0, 8'd0);
            end
            rgbeg_pkg::CfgSpeedLevel: lamp_cfg.speed_level = d[2:0];
            rgbeg_pkg::CfgBrightness: lamp_cfg.brightness = d[3:0];
            rgbeg_pkg::CfgTouchEnable: lamp_cfg.touch_enable = d[0];
            rgbeg_pkg::CfgTouchHue: lamp_cfg.touch_hue = d;
            default: ;
        endcase
    endfunction

    // Palette color k with every lit channel at the given level.
    function automatic void show_color(int unsigned k, logic [7:0] lvl);
        logic [2:0] m;
        m = ChanMask[(k > 6) ? 6 : k];
        set_base(m[2] ? lvl : 8'd0, m[1] ? lvl : 8'd0, m[0] ? lvl : 8'd0);
    endfunction

    function automatic logic [7:0] hue_slope(int unsigned x);
        return (x * 6 > 255) ? 8'd255 : 8'(x * 6);
    endfunction

    function automatic void hue_to_base(int unsigned h);
        if (h < 44) set_base(8'd0, hue_slope(h), 8'd255);
        else if (h < 87) set_base(8'd0, 8'd255, 8'd255 - hue_slope(h - 43));
        else if (h < 130) set_base(hue_slope(h - 86), 8'd255, 8'd0);
        else if (h < 173) set_base(8'd255, 8'd255 - hue_slope(h - 129), 8'd0);
        else if (h < 216) set_base(8'd255, 8'd0, hue_slope(h - 172));
        else set_base(8'd255 - hue_slope(h - 212), 8'd0, 8'd255);
    endfunction

    // Counts one tick and reports whether the period of the current speed has run out.
    function automatic bit period_done(bit slow);
        int unsigned spd;
        spd = (lamp_cfg.speed_level > rgbeg_pkg::SpeedMax) ? rgbeg_pkg::SpeedMax
                                                            : lamp_cfg.speed_level;
        fx_tick = fx_tick + 13'd1;
        if (fx_tick >= (slow ? rgbeg_pkg::StepPeriod[spd] : rgbeg_pkg::FadePeriod[spd])) begin
            fx_tick = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void breathe_fx(int unsigned colors);
        if (period_done(1'b0)) begin
            if (!fx_down) begin
                if (fx_fade != 8'd255) begin
                    fx_fade = fx_fade + 8'd1;
                    if (fx_fade == 8'd255) fx_down = 1'b1;
                end
            end else begin
                if (fx_fade != 8'd0) fx_fade = fx_fade - 8'd1;
                if (fx_fade == 8'd0) begin
                    fx_down = 1'b0;
                    fx_phase = fx_phase + 3'd1;
                    if (fx_phase >= colors) fx_phase = '0;
                end
            end
        end
        show_color((fx_phase >= colors) ? colors - 1 : fx_phase, fx_fade);
    endfunction

    function automatic void rainbow_fx();
        if (period_done(1'b0)) begin
            if (fx_fade != 8'd255) begin
                fx_fade = fx_fade + 8'd1;
            end else begin
                fx_fade = '0;
                fx_phase = fx_phase + 3'd1;
                if (fx_phase >= 6) fx_phase = '0;
            end
        end
        case (fx_phase)
            3'd0: set_base(8'd255, fx_fade, 8'd0);
            3'd1: set_base(8'd255 - fx_fade, 8'd255, 8'd0);
            3'd2: set_base(8'd0, 8'd255, fx_fade);
            3'd3: set_base(8'd0, 8'd255 - fx_fade, 8'd255);
            3'd4: set_base(fx_fade, 8'd0, 8'd255);
            default: set_base(8'd255, 8'd0, 8'd255 - fx_fade);
        endcase
    endfunction

    function automatic void advance_fx(logic [3:0] mode);
        int unsigned colors;
        if (mode <= rgbeg_pkg::ModeWhite) begin
            show_color(mode, 8'd255);
        end else if (mode == rgbeg_pkg::ModeStep3 || mode == rgbeg_pkg::ModeStep7) begin
            colors = (mode == rgbeg_pkg::ModeStep3) ? 3 : 7;
            if (period_done(1'b1)) begin
                fx_phase = fx_phase + 3'd1;
                if (fx_phase >= colors) fx_phase = '0;
            end
            show_color((fx_phase >= colors) ? colors - 1 : fx_phase, 8'd255);
        end else if (mode == rgbeg_pkg::ModeBreathe3) begin
            breathe_fx(3);
        end else if (mode == rgbeg_pkg::ModeBreathe7) begin
            breathe_fx(7);
        end else begin
            rainbow_fx();
        end
    endfunction

    function automatic logic [7:0] dim(logic [7:0] c);
        int unsigned v;
        v = int'(c) * (int'(lamp_cfg.brightness) + 1) / 10;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // Duties that one tick item produces; updates the shadow effect state.
    function automatic rgbeg_pkg::t_out_item next_duties(logic adv);
        logic [3:0]           mode;
        rgbeg_pkg::t_out_item r;
        mode = (lamp_cfg.effect_mode > rgbeg_pkg::ModeRainbow) ? rgbeg_pkg::ModeRainbow
                                                                : lamp_cfg.effect_mode;
        r = '0;
        if (!lamp_cfg.enable) begin
            clear_fx();
            return r;
        end
        if (lamp_cfg.touch_enable) hue_to_base(lamp_cfg.touch_hue);
        else if (adv) advance_fx(mode);
        if (!lamp_cfg.touch_enable && mode >= rgbeg_pkg::ModeBreathe3) begin
            r.red_duty = base.red;
            r.green_duty = base.green;
            r.blue_duty = base.blue;
        end else begin
            r.red_duty = dim(base.red);
            r.green_duty = dim(base.green);
            r.blue_duty = dim(base.blue);
        end
        return r;
    endfunction

    // Stops offering items and waits until every expected result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_duties.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [rgbeg_pkg::CfgIdxWidth-1:0] idx,
                             logic [rgbeg_pkg::CfgDataWidth-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        load_cfg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one tick item after a random gap and records its expected duties.
    task automatic send_item(logic adv, logic typed, rgbeg_pkg::t_out_item want);
        rgbeg_pkg::t_out_item exp_duties;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload.advance <= adv;
        do @(posedge i_clk); while (!in_ch.ready);
        exp_duties = next_duties(adv);
        pending_duties.push_back(typed ? want : exp_duties);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            duty_errors++;
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off when the stimulus asks for one.
    always @(posedge i_clk) begin
        if (stall_request) begin
            stall_left = StallCycles;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checker: each accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_duties.size() == 0) begin
                $error("result item with no expectation pending");
                duty_errors++;
            end else begin
                check_field("red_duty", pending_duties[0].red_duty, out_ch.payload.red_duty);
                check_field("green_duty", pending_duties[0].green_duty,
                            out_ch.payload.green_duty);
                check_field("blue_duty", pending_duties[0].blue_duty,
                            out_ch.payload.blue_duty);
                void'(pending_duties.pop_front());
                duties_checked++;
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HangLimit) begin
            $display("rgb_effect_generator verification failed");
            $finish;
        end
    end

    initial begin
        int        regime;
        int        last_regime;
        int        seg_len;
        bit        stalled;
        logic [7:0] noise;
        logic [3:0] mode;
        logic [2:0] spd;

        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        lamp_cfg = '{enable: 1'b0, effect_mode: rgbeg_pkg::ModeReset,
                     speed_level: rgbeg_pkg::SpeedReset, brightness: rgbeg_pkg::BrightReset,
                     touch_enable: 1'b0, touch_hue: 8'd0};
        clear_fx();
        set_base(8'd0, 8'd0, 8'd0);
        last_regime = -1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        for (int i = 0; i < NumDir; i++) begin
            if (DirRows[i].is_cfg) begin
                cfg_write(DirRows[i].idx, DirRows[i].data);
            end else begin
                send_item(DirRows[i].adv, DirRows[i].typed, DirRows[i].want);
                dir_items++;
            end
        end

        // Random part: runs of ticks between random register settings; most writes leave
        // the mode alone so breathing and rainbow effects get far into their cycles.
        while (rand_items < RandItems) begin
            regime = rand_items * 3 / RandItems;
            stalled = 1'b0;
            if (regime != last_regime) begin
                send_idle_pct = (regime == 0) ? 32 : (regime == 1) ? 81 : 0;
                recv_idle_pct = (regime == 0) ? 81 : (regime == 1) ? 32 : 0;
                last_regime = regime;
                stalled = 1'b1;
            end
            noise = 8'($urandom);
            cfg_write(rgbeg_pkg::CfgEnable, {noise[7:1], ($urandom_range(0, 9) != 0)});
            if ($urandom_range(0, 1) == 1) begin
                noise = 8'($urandom);
                mode = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(7, 15))
                                                  : 4'($urandom_range(0, 15));
                cfg_write(rgbeg_pkg::CfgEffectMode, {noise[7:4], mode});
            end
            if ($urandom_range(0, 9) < 7) begin
                noise = 8'($urandom);
                spd = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 7));
                cfg_write(rgbeg_pkg::CfgSpeedLevel, {noise[7:3], spd});
            end
            if ($urandom_range(0, 1) == 1) cfg_write(rgbeg_pkg::CfgBrightness, 8'($urandom));
            noise = 8'($urandom);
            cfg_write(rgbeg_pkg::CfgTouchEnable, {noise[7:1], ($urandom_range(0, 99) < 15)});
            if ($urandom_range(0, 1) == 1) cfg_write(rgbeg_pkg::CfgTouchHue, 8'($urandom));
            if ($urandom_range(0, 19) == 0) cfg_write(CfgSpare, 8'($urandom));
            setting_changes++;

            seg_len = $urandom_range(10, 300);
            if (stalled) begin
                stall_request = 1'b1;
                if (seg_len < 120) seg_len = 120;
            end
            if (seg_len > RandItems - rand_items) seg_len = RandItems - rand_items;
            for (int k = 0; k < seg_len; k++) begin
                send_item(($urandom_range(0, 9) != 0), 1'b0, '0);
                rand_items++;
            end
        end

        drain();
        repeat (DrainCycles) @(posedge i_clk);

        $display("Covered %0d directed and %0d random tick items over %0d setting changes,",
                 dir_items, rand_items, setting_changes);
        $display("with %0d duty results checked against the effect predictor.",
                 duties_checked);
        if (duty_errors == 0) begin
            $display("rgb_effect_generator verification clean");
        end else begin
            $display("rgb_effect_generator verification failed");
        end
        $finish;
    end

endmodule
